@@ hw/rtl/ecd_pkg.sv @@
// Shared types, constants and helpers for the epoch-to-calendar decoder.
// Used by the stream interface instances, the controller, the datapath and the top level.
package ecd_pkg;

	// Input item: one Unix second count.
	typedef struct packed {
		logic [31:0] epoch_seconds;
	} in_item_t;

	// Result item: local GMT+7 calendar date and time.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [7:0] year;
	} out_item_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_MONTH,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic year_step;
		logic month_step;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic year_done;
		logic tod_done;
		logic month_done;
	} stat_t;

	localparam logic [31:0] LOCAL_OFFSET  = 32'd25200;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;
	localparam logic [7:0]  BASE_YEAR     = 8'd70;
	localparam logic [7:0]  CENTURY       = 8'd100;
	localparam logic [8:0]  DAYS_COMMON   = 9'd365;
	localparam logic [8:0]  DAYS_LEAP     = 9'd366;
	localparam logic [3:0]  LAST_MONTH    = 4'd11;
	localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;

	// Day split cycles: quotient estimate, remainder correction, weekday.
	localparam int          DIV_STEPS     = 3;

	// Seconds / 86400 is taken as (seconds / 128) / 675 with a reciprocal of 675.
	localparam int          DAY_PRE_SHIFT    = 7;
	localparam logic [30:0] DAY_RECIP        = 31'd1628906115;
	localparam int          DAY_RECIP_SHIFT  = 40;

	// Reciprocal of 7, exact for any 16-bit day count.
	localparam logic [16:0] WEEK_RECIP       = 17'd74899;
	localparam int          WEEK_RECIP_SHIFT = 19;

	// Month index constants (0 is January).
	localparam logic [3:0] M_JAN = 4'd0;
	localparam logic [3:0] M_FEB = 4'd1;
	localparam logic [3:0] M_MAR = 4'd2;
	localparam logic [3:0] M_APR = 4'd3;
	localparam logic [3:0] M_MAY = 4'd4;
	localparam logic [3:0] M_JUN = 4'd5;
	localparam logic [3:0] M_JUL = 4'd6;
	localparam logic [3:0] M_AUG = 4'd7;
	localparam logic [3:0] M_SEP = 4'd8;
	localparam logic [3:0] M_OCT = 4'd9;
	localparam logic [3:0] M_NOV = 4'd10;
	localparam logic [3:0] M_DEC = 4'd11;

	// Length of a month in days; February follows the leap flag.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			M_FEB: len = leap ? 5'd29 : 5'd28;
			M_APR, M_JUN, M_SEP, M_NOV: len = 5'd30;
			M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ hw/rtl/ecd_stream_if.sv @@
// Valid/ready stream channel carrying one payload of a given type.
// Payload types come from ecd_pkg at the place of instantiation.
interface ecd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/ecd_ctrl.sv @@
// Controller state machine of the epoch-to-calendar decoder.
// Depends on ecd_pkg for the state, command and status types.
module ecd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ecd_pkg::stat_t stat,
	output ecd_pkg::cmd_t  cmd
);
	import ecd_pkg::*;

	localparam int CntW = $clog2(DIV_STEPS);

	state_t            state_q;
	state_t            state_next;
	logic [CntW-1:0]   cnt_q;
	logic              out_valid_q;
	logic              div_last;

	assign div_last  = (cnt_q == CntW'(DIV_STEPS - 1));
	assign out_valid = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_next = ST_DIV;
			ST_DIV:   if (div_last) state_next = ST_YEAR;
			ST_YEAR:  if (stat.year_done && stat.tod_done) state_next = ST_MONTH;
			ST_MONTH: if (stat.month_done) state_next = ST_EMIT;
			ST_EMIT:  if (!out_valid_q || out_ready) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:   cmd.div_step   = 1'b1;
			ST_YEAR:  cmd.year_step  = 1'b1;
			ST_MONTH: cmd.month_step = 1'b1;
			ST_EMIT:  cmd.load_out   = !out_valid_q || out_ready;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	// State, division step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/ecd_dpath.sv @@
// Datapath of the epoch-to-calendar decoder: reciprocal day split, time-of-day split,
// year and month subtraction, and the result register. Depends on ecd_pkg.
module ecd_dpath (
	input  logic               clk,
	input  ecd_pkg::cmd_t      cmd,
	input  ecd_pkg::in_item_t  din,
	output ecd_pkg::stat_t     stat,
	output ecd_pkg::out_item_t dout
);
	import ecd_pkg::*;

	// Local second count, day count estimate, day count and seconds of day.
	logic [31:0] t_q;
	logic [15:0] qest_q;
	logic [15:0] days_q;
	logic [16:0] rem_q;
	logic [2:0]  wd_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [7:0]  year_q;
	logic [3:0]  mon_q;
	out_item_t   out_q;

	logic [55:0] day_prod;
	logic [15:0] qest_next;
	logic [31:0] rdiff;
	logic        day_fix;
	logic [15:0] days_next;
	logic [16:0] rem_next;
	logic [32:0] wk_prod;
	logic [13:0] q7;
	logic [2:0]  wd_next;

	logic [15:0] days;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [2:0]  weekday;

	// The estimate is the true day count or one below it; one compare fixes it.
	assign day_prod  = 56'(t_q[31:DAY_PRE_SHIFT]) * 56'(DAY_RECIP);
	assign qest_next = day_prod[DAY_RECIP_SHIFT +: 16];
	assign rdiff     = t_q - 32'(qest_q) * 32'(SECS_PER_DAY);
	assign day_fix   = (rdiff >= 32'(SECS_PER_DAY));
	assign days_next = day_fix ? (qest_q + 16'd1) : qest_q;
	assign rem_next  = day_fix ? 17'(rdiff - 32'(SECS_PER_DAY)) : 17'(rdiff);

	// Day count modulo 7 for the weekday.
	assign wk_prod = 33'(days_q) * 33'(WEEK_RECIP);
	assign q7      = wk_prod[WEEK_RECIP_SHIFT +: 14];
	assign wd_next = 3'(days_q - 16'(q7) * 16'(DAYS_PER_WEEK));

	// Calendar stepping against the remaining day count.
	assign days = days_q;
	assign leap = (year_q[1:0] == 2'b00);
	assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
	assign mlen = month_days(mon_q, leap);

	assign stat.year_done  = (days < 16'(ylen));
	assign stat.tod_done   = (rem_q < SECS_PER_MIN);
	assign stat.month_done = (days < 16'(mlen)) || (mon_q == LAST_MONTH);

	// Day 0 of the epoch is a Thursday.
	assign weekday = (wd_q < 3'd3) ? (wd_q + 3'd5) : (wd_q - 3'd2);

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q    <= din.epoch_seconds + LOCAL_OFFSET;
			rem_q  <= '0;
			wd_q   <= '0;
			hour_q <= '0;
			min_q  <= '0;
			year_q <= BASE_YEAR;
			mon_q  <= '0;
		end else if (cmd.div_step) begin
			// Each step refreshes every stage; after the last one all are settled.
			qest_q <= qest_next;
			days_q <= days_next;
			rem_q  <= rem_next;
			wd_q   <= wd_next;
		end else if (cmd.year_step) begin
			if (!stat.year_done) begin
				days_q <= days - 16'(ylen);
				year_q <= year_q + 8'd1;
			end
			// Hours first, then minutes; the remainder ends as the seconds.
			if (rem_q >= SECS_PER_HOUR) begin
				rem_q  <= rem_q - SECS_PER_HOUR;
				hour_q <= hour_q + 5'd1;
			end else if (!stat.tod_done) begin
				rem_q <= rem_q - SECS_PER_MIN;
				min_q <= min_q + 6'd1;
			end
		end else if (cmd.month_step) begin
			if (!stat.month_done) begin
				days_q <= days - 16'(mlen);
				mon_q  <= mon_q + 4'd1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.hour         <= hour_q;
			out_q.minute       <= min_q;
			out_q.second       <= rem_q[5:0];
			out_q.weekday      <= weekday;
			out_q.day_of_month <= days[4:0] + 5'd1;
			out_q.month        <= mon_q + 4'd1;
			out_q.year         <= year_q - CENTURY;
		end
	end

	assign dout = out_q;

endmodule

@@ hw/rtl/epoch_to_calendar_decode_unit.sv @@
// Epoch-to-calendar decoder, GMT+7: top level joining controller and datapath.
// After an input transfer the item passes the day split, the year loop (years and
// time of day stepped together), the month loop and the result load before it is offered.
// One item is decoded at a time; a new item is taken while the previous result waits.
// Reset (arst_n low, asynchronous) empties the block; no result is pending after it.
module epoch_to_calendar_decode_unit (
	input logic       clk,
	input logic       arst_n,
	ecd_stream_if.sink   din,
	ecd_stream_if.source dout
);
	import ecd_pkg::*;

	cmd_t      cmd;
	stat_t     stat;
	in_item_t  in_item;
	out_item_t out_item;

	assign in_item   = din.data;
	assign dout.data = out_item;

	ecd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ecd_dpath u_dpath (
		.clk  (clk),
		.cmd  (cmd),
		.din  (in_item),
		.stat (stat),
		.dout (out_item)
	);

	// A result loaded into the output register is offered in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> dout.valid)
		else $error("loaded result not offered");

	// A taken result with no new load leaves the output empty.
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.ready && !cmd.load_out) |=> !dout.valid)
		else $error("result offered twice");

	// Offered results stay inside the calendar ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.data.hour < 5'd24) && (dout.data.minute < 6'd60)
			&& (dout.data.second < 6'd60) && (dout.data.weekday != 3'd0)
			&& (dout.data.month != 4'd0) && (dout.data.month < 4'd13)
			&& (dout.data.day_of_month != 5'd0))
		else $error("result field out of range");

	// An item is never accepted while a decode is under way.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.year_step || cmd.month_step) |-> !din.ready)
		else $error("input accepted during decode");

endmodule

@@ tb/sv/tb_epoch_to_calendar_decode_unit.sv @@
// Self-checking testbench for the GMT+7 epoch-to-calendar decoder.
// Depends on ecd_pkg and ecd_stream_if; drives the input stream and checks every
// result transfer against an in-bench calendar computation.
module tb_epoch_to_calendar_decode_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ecd_pkg::*;

	localparam logic [31:0] TZ_OFFSET_S      = 32'd25200;
	localparam int unsigned DAY_S            = 86400;
	localparam int unsigned HOUR_S           = 3600;
	localparam int unsigned MINUTE_S         = 60;
	localparam int unsigned FIRST_YEAR       = 70;
	localparam int          RANDOM_PER_PHASE = 358;
	localparam int          NUM_PHASES       = 4;
	localparam int          HOLD_OFF_CYCLES  = 600;
	localparam int          DRAIN_CYCLES     = 200;
	localparam int          WATCHDOG_LIMIT   = 4000;
	localparam int          MAX_REPORTS      = 10;

	// Idle percentages per phase: none, sender only, receiver only, both.
	localparam int SEND_IDLE_PCT[NUM_PHASES] = '{0, 50, 0, 16};
	localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 50, 16};

	logic clk;
	logic arst_n;

	ecd_stream_if #(.T(in_item_t))  din_if ();
	ecd_stream_if #(.T(out_item_t)) dout_if ();

	epoch_to_calendar_decode_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	logic [31:0] epoch_queue[$];
	out_item_t   calendar_queue[$];
	int          items_accepted = 0;
	int          dates_seen = 0;
	int          err_count = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_off;
	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Decode one second count into local calendar fields.
	function automatic out_item_t calc_local_calendar(input logic [31:0] epoch);
		logic [31:0]  t;
		int unsigned  sod;
		int unsigned  days;
		int unsigned  wd;
		int unsigned  yr;
		int unsigned  mon;
		int unsigned  mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		out_item_t    r;
		t    = epoch + TZ_OFFSET_S;
		sod  = t % DAY_S;
		days = t / DAY_S;
		wd   = days % 7;
		r.hour   = 5'(sod / HOUR_S);
		r.minute = 6'((sod / MINUTE_S) % 60);
		r.second = 6'(sod % MINUTE_S);
		// Day 0 was a Thursday; Sunday is 1.
		r.weekday = 3'((wd < 3) ? (5 + wd) : (wd - 2));
		// Strip whole years, every fourth one being leap.
		yr = FIRST_YEAR;
		while (days >= ((yr % 4 == 0) ? 366 : 365)) begin
			days -= (yr % 4 == 0) ? 366 : 365;
			yr++;
		end
		// February length always comes from the year just found.
		mlen[1] = (yr % 4 == 0) ? 29 : 28;
		mon = 0;
		while (mon != 11 && days >= mlen[mon]) begin
			days -= mlen[mon];
			mon++;
		end
		r.day_of_month = 5'(days + 1);
		r.month        = 4'(mon + 1);
		r.year         = 8'(yr - 100);
		return r;
	endfunction

	// Second count that lands on local midnight of a given day since 1970.
	function automatic logic [31:0] local_midnight(input longint day);
		return 32'(day * DAY_S - 25200);
	endfunction

	// Random second count, weighted toward day, month and year edges and the wrap.
	function automatic logic [31:0] random_epoch();
		int unsigned yday_pick[9] = '{0, 30, 31, 58, 59, 60, 333, 364, 365};
		int unsigned kind;
		int unsigned y;
		int unsigned sod;
		longint      day;
		kind = $urandom_range(0, 9);
		if (kind == 4 || kind == 5) begin
			day = $urandom_range(0, 49710);
			return local_midnight(day) - $urandom_range(0, 1);
		end else if (kind == 6) begin
			y   = $urandom_range(70, 205);
			day = (y - 70) * 365 + ((y - 1) / 4 - 17) + yday_pick[$urandom_range(0, 8)];
			case ($urandom_range(0, 2))
				0: sod = 0;
				1: sod = DAY_S - 1;
				default: sod = $urandom_range(0, DAY_S - 1);
			endcase
			return local_midnight(day) + sod;
		end else if (kind == 7) begin
			return 32'hFFFF_FFFF - $urandom_range(0, 30000);
		end
		return $urandom;
	endfunction

	// Input driver: new values at the falling edge once the last offer was taken.
	always @(negedge clk) begin
		if (!din_if.valid || in_taken) begin
			if (epoch_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				din_if.data.epoch_seconds <= epoch_queue.pop_front();
				din_if.valid <= 1'b1;
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus the long hold-off when requested.
	always @(negedge clk) begin
		dout_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: predict on each input transfer, check each result transfer.
	always @(posedge clk) begin : monitor
		out_item_t want;
		in_taken  = din_if.valid && din_if.ready;
		out_taken = dout_if.valid && dout_if.ready;
		if (in_taken) begin
			calendar_queue.push_back(calc_local_calendar(din_if.data.epoch_seconds));
			items_accepted++;
		end
		if (out_taken) begin
			dates_seen++;
			if (calendar_queue.size() == 0) begin
				if (err_count < MAX_REPORTS)
					$display("%0t: result with nothing pending: %p", $realtime, dout_if.data);
				err_count++;
			end else begin
				want = calendar_queue.pop_front();
				if (dout_if.data.hour !== want.hour || dout_if.data.minute !== want.minute ||
						dout_if.data.second !== want.second ||
						dout_if.data.weekday !== want.weekday ||
						dout_if.data.day_of_month !== want.day_of_month ||
						dout_if.data.month !== want.month || dout_if.data.year !== want.year) begin
					if (err_count < MAX_REPORTS)
						$display("%0t: mismatch, expected %p, got %p",
							$realtime, want, dout_if.data);
					err_count++;
				end
			end
		end
		if (in_taken || out_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// Long receiver hold-off early in the first phase so the input backs up.
	initial begin
		hold_off = 1'b0;
		while (dates_seen < 20) @(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog on cycles without any transfer.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Reset, then directed and random items in phases of differing idle patterns.
	initial begin : stimulus
		int n_pushed;
		int phase;
		n_pushed = 0;
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.data = '0;
		dout_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			send_idle_pct  = SEND_IDLE_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			if (phase == 0) begin
				// Range ends and the offset wrap into early 1970.
				epoch_queue.push_back(32'h0000_0000);
				epoch_queue.push_back(32'h0000_0001);
				epoch_queue.push_back(32'hFFFF_FFFF);
				epoch_queue.push_back(32'hFFFF_9D8F);
				epoch_queue.push_back(32'hFFFF_9D90);
				epoch_queue.push_back(32'h7FFF_FFFF);
				epoch_queue.push_back(32'h8000_0000);
				epoch_queue.push_back(32'hAAAA_AAAA);
				epoch_queue.push_back(32'h5555_5555);
				// Last second of the first local day, then the next day.
				epoch_queue.push_back(local_midnight(1) - 1);
				epoch_queue.push_back(local_midnight(1));
				// End of a leap year in the wrapped-year range.
				epoch_queue.push_back(local_midnight(1095) + DAY_S - 1);
				// Turn of the century.
				epoch_queue.push_back(local_midnight(10957) - 1);
				epoch_queue.push_back(local_midnight(10957));
				// February end in a common year and in a leap year.
				epoch_queue.push_back(local_midnight(19416) + DAY_S - 1);
				epoch_queue.push_back(local_midnight(19417));
				epoch_queue.push_back(local_midnight(19781));
				epoch_queue.push_back(local_midnight(19782) + 45296);
				epoch_queue.push_back(local_midnight(19783));
				// 2100 counts as leap under the every-fourth-year rule.
				epoch_queue.push_back(local_midnight(47541));
				epoch_queue.push_back(local_midnight(47542));
				n_pushed += 21;
			end
			repeat (RANDOM_PER_PHASE) begin
				epoch_queue.push_back(random_epoch());
				n_pushed++;
			end
			while (epoch_queue.size() != 0) @(posedge clk);
		end

		while (items_accepted != n_pushed || calendar_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ecd_pkg.sv
hw/rtl/ecd_stream_if.sv
hw/rtl/ecd_ctrl.sv
hw/rtl/ecd_dpath.sv
hw/rtl/epoch_to_calendar_decode_unit.sv
tb/sv/tb_epoch_to_calendar_decode_unit.sv
